/* hdl/estc_pkg.sv */
// Shared types, constants and month table for the epoch-seconds calendar converter.
package estc_pkg;

   // Time constants
   localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
   localparam logic [17:0] SECS_PER_HOUR = 18'd3600;
   localparam logic [17:0] SECS_PER_MIN  = 18'd60;
   localparam logic [10:0] BASE_YEAR     = 11'd1970;

   // Leap-rule residues of the base year
   localparam logic [1:0] BASE_MOD4   = 2'd2;
   localparam logic [6:0] BASE_MOD100 = 7'd70;
   localparam logic [8:0] BASE_MOD400 = 9'd370;

   localparam logic [8:0] DAYS_LEAP   = 9'd366;
   localparam logic [8:0] DAYS_COMMON = 9'd365;

   // Reciprocals of the odd factors: 86400 = 2^7 * 675, 3600 = 2^4 * 225, 60 = 2^2 * 15
   // q = ((x >> s) * ceil(2^k / d)) >> k, exact over the operand range
   localparam logic [24:0] DAY_RECIP  = 25'd25451659;   // ceil(2^34 / 675)
   localparam logic [13:0] HOUR_RECIP = 14'd9321;       // ceil(2^21 / 225)
   localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)

   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   typedef struct packed {
      logic signed [31:0] epoch_seconds;
      logic [19:0]        micro_part;
   } req_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] microsecond;
      logic        before_epoch;
   } rsp_type;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_DAY_DIV,
      DP_DAY_REM,
      DP_HOUR_DIV,
      DP_HOUR_REM,
      DP_MIN_DIV,
      DP_MIN_REM,
      DP_YEAR,
      DP_MONTH,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic neg;
      logic year_fit;
      logic month_fit;
   } dp_status_type;

   // Days in a month, index 0 is January
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* hdl/epoch_seconds_to_calendar.sv */
// Top level: epoch seconds to Gregorian date and time of day.
//
//   channel   dir   handshake                payload
//   req_      in    req_valid / req_ready    req_type: epoch_seconds, micro_part
//   rsp_      out   rsp_valid / rsp_ready    rsp_type: year ... before_epoch
//
// One request at a time: an accept state, six division states (quotient then remainder
// for days, hours and minutes), a year state that steps once per year past 1970, a
// month state that steps once per month, and a finish state that loads the result.
// Negative seconds go from day division straight to finish. The year loop is the longest part.
// Synchronous active-high reset clears the controller and the result valid.
// A result waiting on rsp_ready does not block the next request; the result
// load stalls only if the previous result has still not been taken.
module epoch_seconds_to_calendar
   import estc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   estc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   estc_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/estc_dpath.sv */
// Datapath: reciprocal-multiply division, year and month stepping, result register.
module estc_dpath
   import estc_pkg::*;
(
   input  logic          clock,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   logic [30:0] secs_ff, secs_in;
   logic        neg_ff, neg_in;
   logic [19:0] micro_ff, micro_in;
   logic [14:0] days_ff, days_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  hour_ff, hour_in;
   logic [11:0] hrem_ff, hrem_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [10:0] year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  month_ff, month_in;
   rsp_type     rsp_ff, rsp_in;

   logic [48:0] day_prod;
   logic [16:0] day_back;
   logic [26:0] hour_prod;
   logic [11:0] hour_back;
   logic [20:0] min_prod;
   logic [5:0]  min_back;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic        year_fit;
   logic        month_fit;

   // Quotients by reciprocal multiplication, remainders by multiply-back
   // (each remainder is below a power of two, so only the low bits are kept)
   assign day_prod  = 49'(secs_ff[30:7]) * 49'(DAY_RECIP);
   assign day_back  = {2'd0, days_ff} * SECS_PER_DAY[16:0];
   assign hour_prod = 27'(rem_ff[16:4]) * 27'(HOUR_RECIP);
   assign hour_back = {7'd0, hour_ff} * SECS_PER_HOUR[11:0];
   assign min_prod  = 21'(hrem_ff[11:2]) * 21'(MIN_RECIP);
   assign min_back  = minute_ff * SECS_PER_MIN[5:0];

   // Leap rule from running residues, then year and month lengths
   assign leap      = (mod400_ff == '0) || ((mod100_ff != '0) && (mod4_ff == '0));
   assign ylen      = leap ? DAYS_LEAP : DAYS_COMMON;
   assign mlen      = month_len(month_ff, leap);
   assign year_fit  = ({6'd0, ylen} > days_ff);
   assign month_fit = ({10'd0, mlen} > days_ff) || (month_ff == MONTH_DEC);

   assign status.neg       = neg_ff;
   assign status.year_fit  = year_fit;
   assign status.month_fit = month_fit;

   // Next-state logic per operation
   always_comb begin
      secs_in   = secs_ff;
      neg_in    = neg_ff;
      micro_in  = micro_ff;
      days_in   = days_ff;
      rem_in    = rem_ff;
      hour_in   = hour_ff;
      hrem_in   = hrem_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      rsp_in    = rsp_ff;
      unique case (cmd.op)
         DP_LOAD: begin
            neg_in   = req_data.epoch_seconds[31];
            micro_in = req_data.micro_part;
            secs_in  = req_data.epoch_seconds[30:0];
         end
         DP_DAY_DIV: begin
            // at most 24855 days: 15 bits
            days_in = day_prod[48:34];
         end
         DP_DAY_REM: begin
            rem_in = secs_ff[16:0] - day_back;
         end
         DP_HOUR_DIV: begin
            hour_in = hour_prod[25:21];
         end
         DP_HOUR_REM: begin
            hrem_in = rem_ff[11:0] - hour_back;
         end
         DP_MIN_DIV: begin
            minute_in = min_prod[19:14];
         end
         DP_MIN_REM: begin
            second_in = hrem_ff[5:0] - min_back;
            year_in   = BASE_YEAR;
            mod4_in   = BASE_MOD4;
            mod100_in = BASE_MOD100;
            mod400_in = BASE_MOD400;
            month_in  = MONTH_JAN;
         end
         DP_YEAR: begin
            if (!year_fit) begin
               days_in   = days_ff - {6'd0, ylen};
               year_in   = year_ff + 11'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         DP_MONTH: begin
            if (!month_fit) begin
               days_in  = days_ff - {10'd0, mlen};
               month_in = month_ff + 4'd1;
            end
         end
         DP_EMIT: begin
            if (neg_ff) begin
               rsp_in              = '0;
               rsp_in.before_epoch = 1'b1;
            end else begin
               rsp_in.year         = year_ff;
               rsp_in.month        = month_ff + 4'd1;
               rsp_in.day          = days_ff[4:0] + 5'd1;
               rsp_in.hour         = hour_ff;
               rsp_in.minute       = minute_ff;
               rsp_in.second       = second_ff;
               rsp_in.microsecond  = micro_ff;
               rsp_in.before_epoch = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      neg_ff    <= neg_in;
      micro_ff  <= micro_in;
      days_ff   <= days_in;
      rem_ff    <= rem_in;
      hour_ff   <= hour_in;
      hrem_ff   <= hrem_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/estc_ctrl.sv */
// Controller: sequences division, year and month stepping, and the result handshake.
module estc_ctrl
   import estc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DAY_DIV,
      S_DAY_REM,
      S_HOUR_DIV,
      S_HOUR_REM,
      S_MIN_DIV,
      S_MIN_REM,
      S_YEAR,
      S_MONTH,
      S_FINISH
   } state_type;

   state_type  state_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode
   always_comb begin
      cmd.op = DP_NOP;
      unique case (state_ff)
         S_IDLE:     cmd.op = req_valid ? DP_LOAD : DP_NOP;
         S_DAY_DIV:  cmd.op = status.neg ? DP_NOP : DP_DAY_DIV;
         S_DAY_REM:  cmd.op = DP_DAY_REM;
         S_HOUR_DIV: cmd.op = DP_HOUR_DIV;
         S_HOUR_REM: cmd.op = DP_HOUR_REM;
         S_MIN_DIV:  cmd.op = DP_MIN_DIV;
         S_MIN_REM:  cmd.op = DP_MIN_REM;
         S_YEAR:     cmd.op = DP_YEAR;
         S_MONTH:    cmd.op = DP_MONTH;
         S_FINISH:   cmd.op = out_free ? DP_EMIT : DP_NOP;
         default:    cmd.op = DP_NOP;
      endcase
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Result valid: set when a result loads, cleared when taken
         if ((state_ff == S_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DAY_DIV;
               end
            end
            S_DAY_DIV: begin
               if (status.neg) begin
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_DAY_REM;
               end
            end
            S_DAY_REM:  state_ff <= S_HOUR_DIV;
            S_HOUR_DIV: state_ff <= S_HOUR_REM;
            S_HOUR_REM: state_ff <= S_MIN_DIV;
            S_MIN_DIV:  state_ff <= S_MIN_REM;
            S_MIN_REM:  state_ff <= S_YEAR;
            S_YEAR: begin
               if (status.year_fit) begin
                  state_ff <= S_MONTH;
               end
            end
            S_MONTH: begin
               if (status.month_fit) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
